// ===== hw/rtl/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, widths and codes of the tiled canvas planner.
// ----------------------------------------------------------------------------
package tcp_pkg;

    localparam int TILE_LIMIT_DEF = 16;
    localparam int MAX_SIDE_DEF   = 16384;
    localparam int TILE_SIDE_MAX  = 1024;

    localparam int TILE_CAP_W  = 5;
    localparam int TILE_SIDE_W = 11;
    localparam int IMG_W       = 15;
    localparam int TILES_W     = 5;
    localparam int GRID_ID_W   = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_CAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIDE = 2'd1;

    localparam logic [TILE_CAP_W-1:0]  TILE_CAP_RST  = 5'd4;
    localparam logic [TILE_SIDE_W-1:0] TILE_SIDE_RST = 11'd560;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_MUL1,
        S_MUL2,
        S_DECIDE,
        S_FIT1,
        S_FIT2,
        S_FIT3,
        S_FIT4,
        S_DIV,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        MS_CAND,
        MS_BEST,
        MS_TWH,
        MS_THW
    } mul_sel_t;

endpackage

// ===== hw/rtl/tcp_div.sv =====
// ----------------------------------------------------------------------------
// tcp_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module tcp_div #(
    parameter int DEN_W = 15,
    parameter int QUO_W = 15
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DEN_W+QUO_W-1:0] num,
    input  logic [DEN_W-1:0]       den,
    output logic                   busy,
    output logic                   done,
    output logic [QUO_W-1:0]       quo
);

    localparam int NUM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [QUO_W-1:0] lo_reg;
    logic [QUO_W-1:0] lo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, lo_reg[QUO_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_next  = {lo_reg[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(QUO_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            lo_reg  <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quo  = lo_reg;

endmodule

// ===== hw/rtl/tiled_canvas_planner_core.sv =====
// ----------------------------------------------------------------------------
// tiled_canvas_planner_core
// Picks the tile grid and resize target for one image.
//
// Channels: cfg (index, data) writes the tile cap (index 0) and tile_side
// (index 1); it is always ready and should be used only while idle. img
// carries one word of img_height/img_width; plan returns one word per
// image with the grid, its one-based id and the fitted size.
// The candidate grids number 8 at tile cap 4 and 50 at 16; the divider
// quotient is the canvas side width (15 bits with default parameters).
// Each grid takes two products from the single shared multiplier for the exact
// cross-product compare; the fitted side comes from a one-bit-per-cycle
// divider. One image is worked at a time: img_ready is high only while the
// sequencer is idle, so a new image waits until the last plan has been
// handed to the output register.
// The result sits in an output register, so a new image is accepted while a
// stalled plan word waits; a finished plan holds until that register frees up.
// Reset: tile cap = 4, tile_side = 560, no plan pending.
// ----------------------------------------------------------------------------
module tiled_canvas_planner_core #(
    parameter int TILE_LIMIT = tcp_pkg::TILE_LIMIT_DEF,
    parameter int MAX_SIDE   = tcp_pkg::MAX_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            img_valid,
    output logic                            img_ready,
    input  logic [tcp_pkg::IMG_W-1:0]       img_height,
    input  logic [tcp_pkg::IMG_W-1:0]       img_width,
    output logic                            plan_valid,
    input  logic                            plan_ready,
    output logic [tcp_pkg::TILES_W-1:0]     tile_rows,
    output logic [tcp_pkg::TILES_W-1:0]     tile_cols,
    output logic [tcp_pkg::TILES_W-1:0]     tiles_used,
    output logic [tcp_pkg::GRID_ID_W-1:0]   grid_id,
    output logic [tcp_pkg::IMG_W-1:0]       fitted_height,
    output logic [tcp_pkg::IMG_W-1:0]       fitted_width
);

    import tcp_pkg::*;

    localparam int RC_W   = $clog2(TILE_LIMIT + 1);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CAN_W  = $clog2(TILE_LIMIT * TILE_SIDE_MAX + 1);
    localparam int RS_W   = $clog2(TILE_LIMIT * MAX_SIDE + 1);
    localparam int ID_W   = $clog2(TILE_LIMIT * TILE_LIMIT + 1);
    localparam int MUL_W  = CAN_W + SIDE_W;

    // control
    state_t                 state_reg;
    state_t                 state_next;
    logic [TILE_CAP_W-1:0]  tile_cap_reg;
    logic [TILE_SIDE_W-1:0] tile_side_reg;
    logic                   plan_valid_reg;

    logic     slot_free;
    logic     accept;
    logic     pick_en;
    logic     decide_en;
    logic     lhs_load;
    logic     clamp_en;
    logic     div_start;
    logic     fit_load;
    logic     out_load;
    mul_sel_t mul_sel;

    // working set
    logic [SIDE_W-1:0]      h_reg;
    logic [SIDE_W-1:0]      w_reg;
    logic [RC_W-1:0]        lim_reg;
    logic [TILE_SIDE_W-1:0] t_reg;

    logic [RC_W-1:0]  r_reg;
    logic [RC_W-1:0]  c_reg;
    logic [RC_W-1:0]  area_reg;
    logic [ID_W-1:0]  id_reg;
    logic [CAN_W-1:0] rt_reg;
    logic [CAN_W-1:0] ct_reg;
    logic [RS_W-1:0]  rw_reg;
    logic [RS_W-1:0]  chh_reg;

    logic [CAN_W-1:0]  cp_reg;
    logic [SIDE_W-1:0] cq_reg;
    logic              cup_reg;
    logic [RC_W-1:0]   carea_reg;
    logic [RC_W-1:0]   crows_reg;
    logic [RC_W-1:0]   ccols_reg;
    logic [ID_W-1:0]   cid_reg;
    logic [CAN_W-1:0]  crt_reg;
    logic [CAN_W-1:0]  cct_reg;
    logic              cand_last_reg;

    logic              have_reg;
    logic              bup_reg;
    logic [CAN_W-1:0]  bp_reg;
    logic [SIDE_W-1:0] bq_reg;
    logic [RC_W-1:0]   barea_reg;
    logic [RC_W-1:0]   brows_reg;
    logic [RC_W-1:0]   bcols_reg;
    logic [ID_W-1:0]   bid_reg;
    logic [CAN_W-1:0]  brt_reg;
    logic [CAN_W-1:0]  bct_reg;

    logic [MUL_W-1:0]  prod_reg;
    logic [MUL_W-1:0]  lhs_reg;
    logic [CAN_W-1:0]  th_reg;
    logic [CAN_W-1:0]  tw_reg;
    logic              sel_w_reg;
    logic [CAN_W-1:0]  side_lim_reg;
    logic [CAN_W-1:0]  fh_reg;
    logic [CAN_W-1:0]  fw_reg;

    logic [TILES_W-1:0]   rows_out_reg;
    logic [TILES_W-1:0]   cols_out_reg;
    logic [TILES_W-1:0]   count_out_reg;
    logic [GRID_ID_W-1:0] id_out_reg;
    logic [IMG_W-1:0]     fh_out_reg;
    logic [IMG_W-1:0]     fw_out_reg;

    // combinational
    logic [31:0]            ih32, iw32, mt32, ts32;
    logic [31:0]            hc32, wc32, lc32, tc32;
    logic [SIDE_W-1:0]      h_in, w_in;
    logic [RC_W-1:0]        lim_in;
    logic [TILE_SIDE_W-1:0] t_in;

    logic              pick_rw_le;
    logic [CAN_W-1:0]  pick_p;
    logic [SIDE_W-1:0] pick_q;
    logic [RC_W:0]     area_sum;
    logic              col_fits;
    logic              row_last;

    logic [CAN_W-1:0]  mul_a;
    logic [SIDE_W-1:0] mul_b;
    logic [MUL_W-1:0]  mul_prod;

    logic              better;
    logic [31:0]       h32, w32, t32, brt32, bct32, th32, tw32;
    logic              narrow;
    logic [MUL_W-1:0]  div_num;
    logic [SIDE_W-1:0] div_den;
    logic              div_busy;
    logic              div_done;
    logic [CAN_W-1:0]  div_quo;
    logic [CAN_W-1:0]  other_side;
    logic [31:0]       rows32, cols32, area32, id32, fh32, fw32;

    // ---------------- input clamps ----------------
    always_comb
    begin
        ih32 = 32'(img_height);
        iw32 = 32'(img_width);
        mt32 = 32'(tile_cap_reg);
        ts32 = 32'(tile_side_reg);
        hc32 = (ih32 == 32'd0) ? 32'd1 : ((ih32 > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : ih32);
        wc32 = (iw32 == 32'd0) ? 32'd1 : ((iw32 > 32'(MAX_SIDE)) ? 32'(MAX_SIDE) : iw32);
        lc32 = (mt32 == 32'd0) ? 32'd1 : ((mt32 > 32'(TILE_LIMIT)) ? 32'(TILE_LIMIT) : mt32);
        tc32 = (ts32 == 32'd0) ? 32'd1 :
               ((ts32 > 32'(TILE_SIDE_MAX)) ? 32'(TILE_SIDE_MAX) : ts32);
        h_in   = hc32[SIDE_W-1:0];
        w_in   = wc32[SIDE_W-1:0];
        lim_in = lc32[RC_W-1:0];
        t_in   = tc32[TILE_SIDE_W-1:0];
    end

    // ---------------- grid walk ----------------
    always_comb
    begin
        pick_rw_le = (rw_reg <= chh_reg);
        pick_p     = pick_rw_le ? rt_reg : ct_reg;
        pick_q     = pick_rw_le ? h_reg : w_reg;
        area_sum   = {1'b0, area_reg} + {1'b0, r_reg};
        col_fits   = (area_sum <= {1'b0, lim_reg});
        row_last   = (r_reg == lim_reg);
    end

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        case (mul_sel)
            MS_CAND:
            begin
                mul_a = cp_reg;
                mul_b = bq_reg;
            end
            MS_BEST:
            begin
                mul_a = bp_reg;
                mul_b = cq_reg;
            end
            MS_TWH:
            begin
                mul_a = tw_reg;
                mul_b = h_reg;
            end
            MS_THW:
            begin
                mul_a = th_reg;
                mul_b = w_reg;
            end
            default:
            begin
                mul_a = cp_reg;
                mul_b = bq_reg;
            end
        endcase
        mul_prod = {{SIDE_W{1'b0}}, mul_a} * {{CAN_W{1'b0}}, mul_b};
    end

    // ---------------- compare and fit ----------------
    always_comb
    begin
        if (!have_reg)
        begin
            better = 1'b1;
        end
        else if (cup_reg != bup_reg)
        begin
            better = cup_reg;
        end
        else if (lhs_reg == prod_reg)
        begin
            better = (carea_reg < barea_reg);
        end
        else if (cup_reg)
        begin
            better = (lhs_reg < prod_reg);
        end
        else
        begin
            better = (lhs_reg > prod_reg);
        end

        h32   = 32'(h_reg);
        w32   = 32'(w_reg);
        t32   = 32'(t_reg);
        brt32 = 32'(brt_reg);
        bct32 = 32'(bct_reg);
        th32  = (h32 < t32) ? t32 : ((h32 > brt32) ? brt32 : h32);
        tw32  = (w32 < t32) ? t32 : ((w32 > bct32) ? bct32 : w32);

        // lhs holds tw*h, prod holds th*w
        narrow  = (lhs_reg < prod_reg);
        div_num = narrow ? lhs_reg : prod_reg;
        div_den = narrow ? w_reg : h_reg;

        if (div_quo == '0)
        begin
            other_side = CAN_W'(1);
        end
        else if (div_quo > side_lim_reg)
        begin
            other_side = side_lim_reg;
        end
        else
        begin
            other_side = div_quo;
        end

        rows32 = 32'(brows_reg);
        cols32 = 32'(bcols_reg);
        area32 = 32'(barea_reg);
        id32   = 32'(bid_reg);
        fh32   = 32'(fh_reg);
        fw32   = 32'(fw_reg);
    end

    tcp_div #(
        .DEN_W (SIDE_W),
        .QUO_W (CAN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (img_valid) state_next = S_PICK;
            S_PICK:   state_next = S_MUL1;
            S_MUL1:   state_next = S_MUL2;
            S_MUL2:   state_next = S_DECIDE;
            S_DECIDE: state_next = cand_last_reg ? S_FIT1 : S_MUL1;
            S_FIT1:   state_next = S_FIT2;
            S_FIT2:   state_next = S_FIT3;
            S_FIT3:   state_next = S_FIT4;
            S_FIT4:   state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_DONE;
            S_DONE:   if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        img_ready = 1'b0;
        pick_en   = 1'b0;
        decide_en = 1'b0;
        lhs_load  = 1'b0;
        clamp_en  = 1'b0;
        div_start = 1'b0;
        fit_load  = 1'b0;
        out_load  = 1'b0;
        mul_sel   = MS_CAND;
        case (state_reg)
            S_IDLE:   img_ready = 1'b1;
            S_PICK:   pick_en = 1'b1;
            S_MUL1:   mul_sel = MS_CAND;
            S_MUL2:
            begin
                mul_sel  = MS_BEST;
                lhs_load = 1'b1;
            end
            S_DECIDE:
            begin
                decide_en = 1'b1;
                pick_en   = !cand_last_reg;
            end
            S_FIT1:   clamp_en = 1'b1;
            S_FIT2:   mul_sel = MS_TWH;
            S_FIT3:
            begin
                mul_sel  = MS_THW;
                lhs_load = 1'b1;
            end
            S_FIT4:   div_start = 1'b1;
            S_DIV:    fit_load = div_done;
            S_DONE:   out_load = slot_free;
            default:  img_ready = 1'b0;
        endcase
    end

    assign slot_free = !plan_valid_reg || plan_ready;
    assign accept    = img_valid && img_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tile_cap_reg   <= TILE_CAP_RST;
            tile_side_reg  <= TILE_SIDE_RST;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TILE_CAP:  tile_cap_reg <= cfg_data[TILE_CAP_W-1:0];
                    CFG_TILE_SIDE: tile_side_reg <= cfg_data[TILE_SIDE_W-1:0];
                    default: ;
                endcase
            end
            if (out_load)
            begin
                plan_valid_reg <= 1'b1;
            end
            else if (plan_ready)
            begin
                plan_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_prod;

        if (accept)
        begin
            h_reg    <= h_in;
            w_reg    <= w_in;
            lim_reg  <= lim_in;
            t_reg    <= t_in;
            r_reg    <= RC_W'(1);
            c_reg    <= RC_W'(1);
            area_reg <= RC_W'(1);
            id_reg   <= ID_W'(1);
            rt_reg   <= CAN_W'(t_in);
            ct_reg   <= CAN_W'(t_in);
            rw_reg   <= RS_W'(w_in);
            chh_reg  <= RS_W'(h_in);
            have_reg <= 1'b0;
        end

        if (pick_en)
        begin
            cp_reg        <= pick_p;
            cq_reg        <= pick_q;
            carea_reg     <= area_reg;
            crows_reg     <= r_reg;
            ccols_reg     <= c_reg;
            cid_reg       <= id_reg;
            crt_reg       <= rt_reg;
            cct_reg       <= ct_reg;
            cand_last_reg <= !col_fits && row_last;
            if (col_fits)
            begin
                c_reg    <= c_reg + RC_W'(1);
                area_reg <= area_sum[RC_W-1:0];
                id_reg   <= id_reg + ID_W'(1);
                ct_reg   <= ct_reg + CAN_W'(t_reg);
                chh_reg  <= chh_reg + RS_W'(h_reg);
            end
            else if (!row_last)
            begin
                r_reg    <= r_reg + RC_W'(1);
                c_reg    <= RC_W'(1);
                area_reg <= r_reg + RC_W'(1);
                id_reg   <= id_reg + ID_W'(1);
                rt_reg   <= rt_reg + CAN_W'(t_reg);
                rw_reg   <= rw_reg + RS_W'(w_reg);
                ct_reg   <= CAN_W'(t_reg);
                chh_reg  <= RS_W'(h_reg);
            end
        end

        if (state_reg == S_MUL1)
        begin
            cup_reg <= (32'(cp_reg) >= 32'(cq_reg));
        end

        if (lhs_load)
        begin
            lhs_reg <= prod_reg;
        end

        if (decide_en && better)
        begin
            have_reg  <= 1'b1;
            bup_reg   <= cup_reg;
            bp_reg    <= cp_reg;
            bq_reg    <= cq_reg;
            barea_reg <= carea_reg;
            brows_reg <= crows_reg;
            bcols_reg <= ccols_reg;
            bid_reg   <= cid_reg;
            brt_reg   <= crt_reg;
            bct_reg   <= cct_reg;
        end

        if (clamp_en)
        begin
            th_reg <= th32[CAN_W-1:0];
            tw_reg <= tw32[CAN_W-1:0];
        end

        if (div_start)
        begin
            sel_w_reg    <= narrow;
            side_lim_reg <= narrow ? th_reg : tw_reg;
        end

        if (fit_load)
        begin
            if (sel_w_reg)
            begin
                fh_reg <= other_side;
                fw_reg <= tw_reg;
            end
            else
            begin
                fh_reg <= th_reg;
                fw_reg <= other_side;
            end
        end

        if (out_load)
        begin
            rows_out_reg  <= rows32[TILES_W-1:0];
            cols_out_reg  <= cols32[TILES_W-1:0];
            count_out_reg <= area32[TILES_W-1:0];
            id_out_reg    <= id32[GRID_ID_W-1:0];
            fh_out_reg    <= fh32[IMG_W-1:0];
            fw_out_reg    <= fw32[IMG_W-1:0];
        end
    end

    assign cfg_ready     = 1'b1;
    assign plan_valid    = plan_valid_reg;
    assign tile_rows     = rows_out_reg;
    assign tile_cols     = cols_out_reg;
    assign tiles_used    = count_out_reg;
    assign grid_id       = id_out_reg;
    assign fitted_height = fh_out_reg;
    assign fitted_width  = fw_out_reg;

    // ---------------- checks ----------------
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_busy || div_done))
        else $error("divide step with idle divider");

    a_cand_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (carea_reg != '0) && (carea_reg <= lim_reg))
        else $error("candidate grid exceeds tile limit");

    a_plan_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(plan_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("plan word raised outside the handoff step");

endmodule
